>>> rtl/rdx_pkg.sv
// Shared types, constants and helpers for the signed integer to radix digits unit.
// No dependencies; every other file in rtl/ imports this package.
package rdx_pkg;

  localparam int MAX_SYMBOLS_DEF = 16;
  localparam int VALUE_BITS_DEF  = 32;
  localparam int VALUE_W         = 32;
  localparam int CFG_DATA_W      = 64;
  localparam int CFG_INDEX_W     = 2;
  localparam int RADIX_W         = 5;
  localparam int DIGIT_W         = 4;
  localparam int CHAR_W          = 8;
  localparam int SYMBOL_COUNT    = 16;
  localparam int SYMBOLS_W       = SYMBOL_COUNT * CHAR_W;
  localparam int QUEUE_DEPTH     = 2;
  localparam int BITS_PER_CYCLE  = 8;

  localparam logic [CFG_INDEX_W-1:0] REG_RADIX        = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SYMBOLS_LOW  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_SYMBOLS_HIGH = 2'd2;

  localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2b;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2d;
  localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;

  localparam logic [RADIX_W-1:0]    RADIX_RESET        = 5'd10;
  localparam logic [CFG_DATA_W-1:0] SYMBOLS_LOW_RESET  = 64'h3736_3534_3332_3130;
  localparam logic [CFG_DATA_W-1:0] SYMBOLS_HIGH_RESET = 64'h0000_0000_0000_3938;

  typedef struct packed {
    logic [RADIX_W-1:0]   radix;
    logic [SYMBOLS_W-1:0] symbols;
  } cfg_t;

  typedef struct packed {
    logic bad;
    logic neg;
  } item_flags_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DIV,
    ST_SIGN,
    ST_DIGITS,
    ST_BAD
  } back_state_t;

  function automatic logic [CHAR_W-1:0] symbol_of(input logic [SYMBOLS_W-1:0] symbols,
                                                  input logic [DIGIT_W-1:0] digit);
    return symbols[digit*CHAR_W +: CHAR_W];
  endfunction

endpackage

>>> rtl/rdx_fifo.sv
// Small register queue between the front and back halves of the converter.
// Depends on rdx_pkg for the default depth.
module rdx_fifo import rdx_pkg::*; #(
  parameter int W     = 2 + VALUE_BITS_DEF,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] wdata,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         full,
  output logic         empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [W-1:0]     mem [DEPTH];
  logic [PTR_W-1:0] wptr;
  logic [PTR_W-1:0] rptr;
  logic [CNT_W-1:0] count;

  assign full  = (count == CNT_W'(DEPTH));
  assign empty = (count == '0);
  assign rdata = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == PTR_W'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == PTR_W'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= wdata;
    end
  end

endmodule

>>> rtl/rdx_div.sv
// Iterative divider by a small radix: restoring division, BITS_PER_CYCLE bits a cycle.
// Depends on rdx_pkg for widths.
module rdx_div import rdx_pkg::*; #(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [VALUE_BITS-1:0] dividend,
  input  logic [RADIX_W-1:0]    divisor,
  output logic                  done,
  output logic [VALUE_BITS-1:0] quotient,
  output logic [DIGIT_W-1:0]    remainder
);

  localparam int STEP  = BITS_PER_CYCLE;
  localparam int CYC   = (VALUE_BITS + STEP - 1) / STEP;
  localparam int PAD   = CYC * STEP;
  localparam int CYC_W = $clog2(CYC + 1);

  logic [PAD-1:0]     sh;
  logic [PAD-1:0]     sh_next;
  logic [RADIX_W-1:0] rem;
  logic [RADIX_W-1:0] rem_next;
  logic [CYC_W-1:0]   left;
  logic               busy;

  // Shift dividend bits into the partial remainder; quotient bits fill from the bottom.
  always_comb begin
    sh_next  = sh;
    rem_next = rem;
    for (int k = 0; k < STEP; k++) begin
      rem_next = {rem_next[RADIX_W-2:0], sh_next[PAD-1]};
      sh_next  = {sh_next[PAD-2:0], 1'b0};
      if (rem_next >= divisor) begin
        rem_next   = rem_next - divisor;
        sh_next[0] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      left <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        left <= CYC_W'(CYC);
      end else if (busy) begin
        left <= left - 1'b1;
        if (left == CYC_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sh  <= PAD'(dividend);
      rem <= '0;
    end else if (busy) begin
      sh  <= sh_next;
      rem <= rem_next;
    end
  end

  assign quotient  = sh[VALUE_BITS-1:0];
  assign remainder = rem[DIGIT_W-1:0];

endmodule

>>> rtl/rdx_front.sv
// Front half: configuration registers, alphabet check and magnitude/sign split.
// Depends on rdx_pkg; feeds rdx_fifo and hands the configuration to rdx_back.
module rdx_front import rdx_pkg::*; #(
  parameter int MAX_SYMBOLS = MAX_SYMBOLS_DEF,
  parameter int VALUE_BITS  = VALUE_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic signed [VALUE_W-1:0] value,
  input  logic                    cfg_we,
  input  logic [CFG_INDEX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data,
  input  logic                    q_full,
  output logic                    q_push,
  output logic [VALUE_BITS+1:0]   q_wdata,
  output cfg_t                    cfg
);

  logic [RADIX_W-1:0]    radix;
  logic [CFG_DATA_W-1:0] symbols_low;
  logic [CFG_DATA_W-1:0] symbols_high;
  logic                  alphabet_ok;
  logic [VALUE_BITS-1:0] raw;
  logic [VALUE_BITS-1:0] mag;
  item_flags_t           flags;

  always_ff @(posedge clk) begin
    if (rst) begin
      radix        <= RADIX_RESET;
      symbols_low  <= SYMBOLS_LOW_RESET;
      symbols_high <= SYMBOLS_HIGH_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_RADIX:        radix        <= cfg_data[RADIX_W-1:0];
        REG_SYMBOLS_LOW:  symbols_low  <= cfg_data;
        REG_SYMBOLS_HIGH: symbols_high <= cfg_data;
        default: ;
      endcase
    end
  end

  assign cfg.radix   = radix;
  assign cfg.symbols = {symbols_high, symbols_low};

  // Reject a radix out of range, and reserved or repeated symbols among the first radix entries.
  always_comb begin
    logic [CHAR_W-1:0] sym_i;
    alphabet_ok = (radix >= RADIX_W'(2)) && (radix <= RADIX_W'(MAX_SYMBOLS))
                  && (radix <= RADIX_W'(SYMBOL_COUNT));
    for (int i = 0; i < SYMBOL_COUNT; i++) begin
      sym_i = symbol_of(cfg.symbols, DIGIT_W'(i));
      if (RADIX_W'(i) < radix) begin
        if (sym_i == CHAR_NUL || sym_i == CHAR_PLUS || sym_i == CHAR_MINUS) begin
          alphabet_ok = 1'b0;
        end
        for (int j = i + 1; j < SYMBOL_COUNT; j++) begin
          if (RADIX_W'(j) < radix && symbol_of(cfg.symbols, DIGIT_W'(j)) == sym_i) begin
            alphabet_ok = 1'b0;
          end
        end
      end
    end
  end

  assign raw       = value[VALUE_BITS-1:0];
  // Two's complement of the most negative value wraps to itself, the correct magnitude.
  assign mag       = raw[VALUE_BITS-1] ? (~raw + 1'b1) : raw;
  assign flags.bad = !alphabet_ok;
  assign flags.neg = raw[VALUE_BITS-1];

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;
  assign q_wdata  = {flags, mag};

endmodule

>>> rtl/rdx_back.sv
// Back half: digit generation by repeated division, digit store and character output.
// Depends on rdx_pkg and rdx_div; takes words from rdx_fifo.
module rdx_back import rdx_pkg::*; #(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  q_empty,
  output logic                  q_pop,
  input  logic [VALUE_BITS+1:0] q_rdata,
  input  cfg_t                  cfg,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [CHAR_W-1:0]     out_char,
  output logic                  last,
  output logic                  alphabet_bad
);

  localparam int IDX_W = $clog2(VALUE_BITS);

  back_state_t           state;
  back_state_t           state_next;
  item_flags_t           q_flags;
  logic [VALUE_BITS-1:0] q_mag;
  logic [VALUE_BITS-1:0] mag;
  logic                  neg;
  logic [IDX_W-1:0]      cnt;
  logic [IDX_W-1:0]      idx;
  logic [DIGIT_W-1:0]    digit_store [VALUE_BITS];
  logic                  div_done;
  logic [VALUE_BITS-1:0] div_quo;
  logic [DIGIT_W-1:0]    div_rem;
  logic                  ld;
  logic                  emit;
  logic [CHAR_W-1:0]     emit_char;
  logic                  emit_last;
  logic                  emit_bad;

  assign {q_flags, q_mag} = q_rdata;
  assign ld = !out_valid || out_ready;

  rdx_div #(
    .VALUE_BITS (VALUE_BITS)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (state == ST_LOAD),
    .dividend  (mag),
    .divisor   (cfg.radix),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    emit       = 1'b0;
    emit_char  = CHAR_NUL;
    emit_last  = 1'b0;
    emit_bad   = 1'b0;
    case (state)
      ST_IDLE: begin
        if (!q_empty) begin
          q_pop      = 1'b1;
          state_next = q_flags.bad ? ST_BAD : ST_LOAD;
        end
      end
      ST_LOAD: begin
        state_next = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) begin
          if (div_quo == '0) begin
            state_next = neg ? ST_SIGN : ST_DIGITS;
          end else begin
            state_next = ST_LOAD;
          end
        end
      end
      ST_SIGN: begin
        if (ld) begin
          emit       = 1'b1;
          emit_char  = CHAR_MINUS;
          state_next = ST_DIGITS;
        end
      end
      ST_DIGITS: begin
        if (ld) begin
          emit      = 1'b1;
          emit_char = symbol_of(cfg.symbols, digit_store[idx]);
          emit_last = (idx == '0);
          if (idx == '0) begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_BAD: begin
        if (ld) begin
          emit       = 1'b1;
          emit_last  = 1'b1;
          emit_bad   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Working registers: digits go in least significant first, come out from idx down.
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && !q_empty) begin
      mag <= q_mag;
      neg <= q_flags.neg;
      cnt <= '0;
    end
    if (state == ST_DIV && div_done) begin
      digit_store[cnt] <= div_rem;
      cnt              <= cnt + 1'b1;
      mag              <= div_quo;
      if (div_quo == '0) begin
        idx <= cnt;
      end
    end
    if (state == ST_DIGITS && ld) begin
      idx <= idx - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ld) begin
      out_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (ld && emit) begin
      out_char     <= emit_char;
      last         <= emit_last;
      alphabet_bad <= emit_bad;
    end
  end

endmodule

>>> rtl/signed_int_to_radix_digits_unit.sv
// Top level of the signed integer to radix digits unit.
// Depends on rdx_pkg, rdx_front, rdx_fifo, rdx_back (which holds rdx_div).
//
//  channel   signals                                   direction  moves
//  --------  ----------------------------------------  ---------  -----------------------------
//  input     in_valid, in_ready, value                 in         one signed value per word
//  output    out_valid, out_ready, out_char, last,     out        one character per word
//            alphabet_bad
//  config    cfg_we, cfg_index, cfg_data               in         one register write per cycle
//
// Steps: the back half takes a word from the queue, then for each digit runs the radix
//   divider (8 quotient bits a cycle), then emits the sign and digit characters, each
//   held until taken. A word flagged bad yields a single alphabet_bad character instead.
// The front half takes a new value while the back half works, up to two words queued.
// Reset (rst, synchronous) restores radix 10 with symbols "0123456789" and empties the queue.
// A character holds in the output register until taken; the emit steps wait behind it.
module signed_int_to_radix_digits_unit import rdx_pkg::*; #(
  parameter int MAX_SYMBOLS = MAX_SYMBOLS_DEF,
  parameter int VALUE_BITS  = VALUE_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [VALUE_W-1:0] value,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [CHAR_W-1:0]         out_char,
  output logic                      last,
  output logic                      alphabet_bad,
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]     cfg_data
);

  localparam int ENTRY_W = VALUE_BITS + 2;

  logic               q_push;
  logic               q_pop;
  logic               q_full;
  logic               q_empty;
  logic [ENTRY_W-1:0] q_wdata;
  logic [ENTRY_W-1:0] q_rdata;
  cfg_t               cfg;

  // Front: hold configuration, classify each value (alphabet state, sign, magnitude).
  rdx_front #(
    .MAX_SYMBOLS (MAX_SYMBOLS),
    .VALUE_BITS  (VALUE_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .value     (value),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_wdata   (q_wdata),
    .cfg       (cfg)
  );

  // Queue: decouple classification from the long conversion.
  rdx_fifo #(
    .W     (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .full  (q_full),
    .empty (q_empty)
  );

  // Back: divide out digits, then stream sign and symbols most significant first.
  rdx_back #(
    .VALUE_BITS (VALUE_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_empty      (q_empty),
    .q_pop        (q_pop),
    .q_rdata      (q_rdata),
    .cfg          (cfg),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_char     (out_char),
    .last         (last),
    .alphabet_bad (alphabet_bad)
  );

endmodule
